/* sv/integer_alu_with_rotate_defines.svh */
// Assertion macros for the integer ALU with rotate.
// Included by integer_alu_with_rotate.sv, which checks its own logic; no dependencies.
`ifndef INTEGER_ALU_WITH_ROTATE_DEFINES_SVH
`define INTEGER_ALU_WITH_ROTATE_DEFINES_SVH
`ifndef ASSERT_OFF
`define IALU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define IALU_ASSERT_IF(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> prop) else $error(msg);
`else
`define IALU_ASSERT(lbl, prop, msg)
`define IALU_ASSERT_IF(lbl, cond, prop, msg)
`endif
`endif

/* sv/ialu_pkg.sv */
// Shared types and constants of the integer ALU with rotate.
// No dependencies.
package ialu_pkg;

  typedef enum logic [4:0] {
    CMD_ADD  = 5'd0,
    CMD_SUB  = 5'd1,
    CMD_MUL  = 5'd2,
    CMD_DIV  = 5'd3,
    CMD_MOD  = 5'd4,
    CMD_AND  = 5'd5,
    CMD_OR   = 5'd6,
    CMD_XOR  = 5'd7,
    CMD_SHL  = 5'd8,
    CMD_SHR  = 5'd9,
    CMD_ROTL = 5'd10,
    CMD_ROTR = 5'd11,
    CMD_LT   = 5'd12,
    CMD_GT   = 5'd13,
    CMD_LTE  = 5'd14,
    CMD_GTE  = 5'd15,
    CMD_EQ   = 5'd16,
    CMD_NEQ  = 5'd17,
    CMD_NOT  = 5'd18
  } cmd_e;

  localparam int unsigned XLEN = 64;
  localparam int unsigned NARROW_WIDTH = 32;
  localparam int unsigned DIV_STAGES = XLEN;
  localparam int unsigned LATENCY = DIV_STAGES + 4;

  typedef struct packed {
    logic             valid;
    logic [4:0]       cmd;
    logic             narrow;
    logic [XLEN-1:0]  side;
    logic             neg_q;
    logic             neg_r;
    logic             err;
    logic [XLEN-1:0]  rem;
    logic [XLEN-1:0]  quo;
    logic [XLEN-1:0]  dvs;
  } stage_t;

  function automatic logic [XLEN-1:0] sext_word(logic [XLEN-1:0] x, logic [6:0] sh);
    logic [XLEN-1:0] t;
    t = x << sh;
    return XLEN'($signed(t) >>> sh);
  endfunction

endpackage

/* sv/ialu_mul.sv */
// Two-stage 64-bit multiplier keeping the low word of the product.
// Depends on ialu_pkg.
module ialu_mul (
  input  logic                        clk_i,
  input  logic [ialu_pkg::XLEN-1:0]   a_i,
  input  logic [ialu_pkg::XLEN-1:0]   b_i,
  output logic [ialu_pkg::XLEN-1:0]   prod_o
);

  logic [63:0] p0_q;
  logic [31:0] p1_q;
  logic [31:0] p2_q;
  logic [63:0] p1_full;
  logic [63:0] p2_full;
  logic [ialu_pkg::XLEN-1:0] prod_q;

  assign p1_full = a_i[31:0] * b_i[63:32];
  assign p2_full = a_i[63:32] * b_i[31:0];

  always_ff @(posedge clk_i) begin
    p0_q   <= a_i[31:0] * b_i[31:0];
    p1_q   <= p1_full[31:0];
    p2_q   <= p2_full[31:0];
    prod_q <= p0_q + {p1_q + p2_q, 32'd0};
  end

  assign prod_o = prod_q;

endmodule

/* sv/ialu_front.sv */
// Decode stage: add, sub, logic, shift and compare results, and set-up of the divider words.
// Depends on ialu_pkg.
module ialu_front #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [4:0]                  cmd_i,
  input  logic [ialu_pkg::XLEN-1:0]   a_i,
  input  logic [ialu_pkg::XLEN-1:0]   b_i,
  input  logic [ialu_pkg::XLEN-1:0]   b_raw_i,
  input  logic                        narrow_i,
  output ialu_pkg::stage_t            stage_o
);

  ialu_pkg::stage_t stage_d, stage_q;
  logic [5:0]  sh;
  logic        sh_big;
  logic        na, nb;
  logic [ialu_pkg::XLEN-1:0] ma, mb;
  logic [6:0]  rot_w;

  assign sh     = b_raw_i[5:0];
  assign sh_big = {1'b0, sh} >= 7'(DATA_WIDTH);
  assign na     = a_i[ialu_pkg::XLEN-1];
  assign nb     = b_i[ialu_pkg::XLEN-1];
  assign ma     = na ? -a_i : a_i;
  assign mb     = nb ? -b_i : b_i;
  assign rot_w  = narrow_i ? 7'(ialu_pkg::NARROW_WIDTH) : 7'(DATA_WIDTH);

  always_comb begin
    stage_d        = '0;
    stage_d.valid  = valid_i;
    stage_d.cmd    = cmd_i;
    stage_d.narrow = narrow_i;
    stage_d.neg_q  = na ^ nb;
    stage_d.neg_r  = na;
    case (cmd_i)
      ialu_pkg::CMD_ADD: stage_d.side = a_i + b_i;
      ialu_pkg::CMD_SUB: stage_d.side = a_i - b_i;
      ialu_pkg::CMD_AND: stage_d.side = a_i & b_i;
      ialu_pkg::CMD_OR:  stage_d.side = a_i | b_i;
      ialu_pkg::CMD_XOR: stage_d.side = a_i ^ b_i;
      ialu_pkg::CMD_NOT: stage_d.side = ~a_i;
      ialu_pkg::CMD_SHL: stage_d.side = sh_big ? '0 : (a_i << sh);
      ialu_pkg::CMD_SHR: begin
        stage_d.side = sh_big ? {ialu_pkg::XLEN{na}}
                              : ialu_pkg::XLEN'($signed(a_i) >>> sh);
      end
      ialu_pkg::CMD_LT:  stage_d.side = ialu_pkg::XLEN'($signed(a_i) < $signed(b_i));
      ialu_pkg::CMD_GT:  stage_d.side = ialu_pkg::XLEN'($signed(a_i) > $signed(b_i));
      ialu_pkg::CMD_LTE: stage_d.side = ialu_pkg::XLEN'($signed(a_i) <= $signed(b_i));
      ialu_pkg::CMD_GTE: stage_d.side = ialu_pkg::XLEN'($signed(a_i) >= $signed(b_i));
      ialu_pkg::CMD_EQ:  stage_d.side = ialu_pkg::XLEN'(a_i == b_i);
      ialu_pkg::CMD_NEQ: stage_d.side = ialu_pkg::XLEN'(a_i != b_i);
      ialu_pkg::CMD_DIV, ialu_pkg::CMD_MOD: begin
        stage_d.err = (b_i == '0);
        stage_d.quo = ma;
        stage_d.dvs = mb;
      end
      ialu_pkg::CMD_ROTL, ialu_pkg::CMD_ROTR: begin
        stage_d.side = a_i;
        stage_d.quo  = b_raw_i;
        stage_d.dvs  = ialu_pkg::XLEN'(rot_w);
      end
      default: stage_d.side = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q.valid <= 1'b0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

/* sv/ialu_div_stage.sv */
// One restoring-division step: one quotient bit per register stage.
// Depends on ialu_pkg.
module ialu_div_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ialu_pkg::stage_t   stage_i,
  output ialu_pkg::stage_t   stage_o
);

  ialu_pkg::stage_t stage_d, stage_q;
  logic [ialu_pkg::XLEN-1:0] trial;
  logic                      ge;

  assign trial = {stage_i.rem[ialu_pkg::XLEN-2:0], stage_i.quo[ialu_pkg::XLEN-1]};
  assign ge    = trial >= stage_i.dvs;

  always_comb begin
    stage_d     = stage_i;
    stage_d.rem = ge ? trial - stage_i.dvs : trial;
    stage_d.quo = {stage_i.quo[ialu_pkg::XLEN-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q.valid <= 1'b0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

/* sv/ialu_back.sv */
// Final stage: quotient and remainder signs, rotate, width fold, output word.
// Depends on ialu_pkg.
module ialu_back #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ialu_pkg::stage_t            stage_i,
  output logic                        done_o,
  output logic [ialu_pkg::XLEN-1:0]   result_o,
  output logic                        divide_error_o
);

  localparam logic [6:0] WordShift = 7'(ialu_pkg::XLEN - DATA_WIDTH);

  logic [6:0]                rot_w;
  logic [6:0]                n;
  logic [ialu_pkg::XLEN-1:0] mask, x, rot, res;
  logic                      done_q, err_q;
  logic [ialu_pkg::XLEN-1:0] result_q;

  assign rot_w = stage_i.narrow ? 7'(ialu_pkg::NARROW_WIDTH) : 7'(DATA_WIDTH);
  assign n     = stage_i.rem[6:0];
  assign mask  = {ialu_pkg::XLEN{1'b1}} >> (7'(ialu_pkg::XLEN) - rot_w);
  assign x     = stage_i.side & mask;

  always_comb begin
    if (n == 7'd0) begin
      rot = x;
    end else if (stage_i.cmd == ialu_pkg::CMD_ROTL) begin
      rot = ((x << n) | (x >> (rot_w - n))) & mask;
    end else begin
      rot = ((x >> n) | (x << (rot_w - n))) & mask;
    end
  end

  always_comb begin
    case (stage_i.cmd)
      ialu_pkg::CMD_DIV: begin
        res = stage_i.err ? '0 : (stage_i.neg_q ? -stage_i.quo : stage_i.quo);
      end
      ialu_pkg::CMD_MOD: begin
        res = stage_i.err ? '0 : (stage_i.neg_r ? -stage_i.rem : stage_i.rem);
      end
      ialu_pkg::CMD_ROTL, ialu_pkg::CMD_ROTR: res = rot;
      default: res = stage_i.side;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= ialu_pkg::sext_word(res, WordShift);
    err_q    <= stage_i.err;
  end

  assign done_o         = done_q;
  assign result_o       = result_q;
  assign divide_error_o = done_q & err_q;

endmodule

/* sv/integer_alu_with_rotate.sv */
// Integer ALU with rotate: add, sub, mul, div, mod, logic, shifts, rotates,
// signed compares. A word is taken every cycle (busy stays low); its result
// is on result_o with done_o high after the input register, decode stage, s2
// register, the 64-step division pipeline that also reduces rotate amounts
// and output register. Results cannot be held off and must be taken as they come.
`include "integer_alu_with_rotate_defines.svh"
module integer_alu_with_rotate #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  logic [4:0]   command_i,
  input  logic [63:0]  operand_a_i,
  input  logic [63:0]  operand_b_i,
  input  logic         narrow_rotate_i,
  output logic         done_o,
  output logic [63:0]  result_o,
  output logic         divide_error_o
);

  localparam logic [6:0] WordShift = 7'(ialu_pkg::XLEN - DATA_WIDTH);

  logic                      s0_valid_q;
  logic [4:0]                s0_cmd_q;
  logic [ialu_pkg::XLEN-1:0] s0_a_q, s0_b_q, s0_braw_q;
  logic                      s0_narrow_q;
  logic [ialu_pkg::XLEN-1:0] prod;
  ialu_pkg::stage_t          s1, s2_q, s2_merged;
  ialu_pkg::stage_t          div_pipe [ialu_pkg::DIV_STAGES+1];

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_cmd_q    <= command_i;
    s0_a_q      <= ialu_pkg::sext_word(operand_a_i, WordShift);
    s0_b_q      <= ialu_pkg::sext_word(operand_b_i, WordShift);
    s0_braw_q   <= operand_b_i;
    s0_narrow_q <= narrow_rotate_i;
  end

  ialu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s0_valid_q),
    .cmd_i    (s0_cmd_q),
    .a_i      (s0_a_q),
    .b_i      (s0_b_q),
    .b_raw_i  (s0_braw_q),
    .narrow_i (s0_narrow_q),
    .stage_o  (s1)
  );

  ialu_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (s0_a_q),
    .b_i    (s0_b_q),
    .prod_o (prod)
  );

  // prod is one stage later than s1, so merge it after s2 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q.valid <= 1'b0;
    end else begin
      s2_q <= s1;
    end
  end

  always_comb begin
    s2_merged = s2_q;
    if (s2_q.cmd == ialu_pkg::CMD_MUL) begin
      s2_merged.side = prod;
    end
  end

  assign div_pipe[0] = s2_merged;

  for (genvar i = 0; i < ialu_pkg::DIV_STAGES; i++) begin : g_div
    ialu_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (div_pipe[i]),
      .stage_o (div_pipe[i+1])
    );
  end

  ialu_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stage_i        (div_pipe[ialu_pkg::DIV_STAGES]),
    .done_o         (done_o),
    .result_o       (result_o),
    .divide_error_o (divide_error_o)
  );

  `IALU_ASSERT_IF(a_err_zero, divide_error_o, result_o == '0, "error word with nonzero result")
  `IALU_ASSERT_IF(a_latency, start && !busy, ##68 done_o, "result missing after latency")
  `IALU_ASSERT_IF(a_no_spurious, done_o, $past(start, 68), "result without a start")
  `IALU_ASSERT_IF(a_err_cmd, s2_q.valid && s2_q.err,
                  s2_q.cmd == ialu_pkg::CMD_DIV || s2_q.cmd == ialu_pkg::CMD_MOD,
                  "error flag on a non-divide word")

endmodule
